@@ design/stt_pkg.sv @@
// Shared types and constants for the source text tokenizer.
// No dependencies; used by the interfaces, the scanner, the queue and the top level.
`timescale 1ns / 1ps

package stt_pkg;

	localparam logic [5:0] K_LPAREN = 6'd0;
	localparam logic [5:0] K_RPAREN = 6'd1;
	localparam logic [5:0] K_LBRACE = 6'd2;
	localparam logic [5:0] K_RBRACE = 6'd3;
	localparam logic [5:0] K_COMMA  = 6'd4;
	localparam logic [5:0] K_DOT    = 6'd5;
	localparam logic [5:0] K_SEMI   = 6'd6;
	localparam logic [5:0] K_PLUS   = 6'd7;
	localparam logic [5:0] K_PLUSEQ = 6'd8;
	localparam logic [5:0] K_MINUS  = 6'd9;
	localparam logic [5:0] K_MINUSEQ = 6'd10;
	localparam logic [5:0] K_STAR   = 6'd11;
	localparam logic [5:0] K_STAREQ = 6'd12;
	localparam logic [5:0] K_SLASH  = 6'd13;
	localparam logic [5:0] K_SLASHEQ = 6'd14;
	localparam logic [5:0] K_PERCENT = 6'd15;
	localparam logic [5:0] K_CARET  = 6'd16;
	localparam logic [5:0] K_AMP    = 6'd17;
	localparam logic [5:0] K_ANDAND = 6'd18;
	localparam logic [5:0] K_PIPE   = 6'd19;
	localparam logic [5:0] K_OROR   = 6'd20;
	localparam logic [5:0] K_TILDE  = 6'd21;
	localparam logic [5:0] K_BANG   = 6'd22;
	localparam logic [5:0] K_NE     = 6'd23;
	localparam logic [5:0] K_ASSIGN = 6'd24;
	localparam logic [5:0] K_EQEQ   = 6'd25;
	localparam logic [5:0] K_LT     = 6'd26;
	localparam logic [5:0] K_LE     = 6'd27;
	localparam logic [5:0] K_GT     = 6'd28;
	localparam logic [5:0] K_GE     = 6'd29;
	localparam logic [5:0] K_IDENT  = 6'd30;
	localparam logic [5:0] K_NUMBER = 6'd31;
	localparam logic [5:0] K_CHAR   = 6'd32;
	localparam logic [5:0] K_LET    = 6'd33;
	localparam logic [5:0] K_PRINT  = 6'd34;
	localparam logic [5:0] K_INPUT  = 6'd35;
	localparam logic [5:0] K_NIL    = 6'd36;
	localparam logic [5:0] K_TRUE   = 6'd37;
	localparam logic [5:0] K_FALSE  = 6'd38;
	localparam logic [5:0] K_IF     = 6'd39;
	localparam logic [5:0] K_ELSE   = 6'd40;
	localparam logic [5:0] K_WHILE  = 6'd41;
	localparam logic [5:0] K_FOR    = 6'd42;
	localparam logic [5:0] K_BREAK  = 6'd43;
	localparam logic [5:0] K_CONTINUE = 6'd44;
	localparam logic [5:0] K_INT    = 6'd45;
	localparam logic [5:0] K_LONG   = 6'd46;
	localparam logic [5:0] K_DOUBLE = 6'd47;
	localparam logic [5:0] K_FLOAT  = 6'd48;
	localparam logic [5:0] K_BOOL   = 6'd49;
	localparam logic [5:0] K_CHARKW = 6'd50;
	localparam logic [5:0] K_EOF    = 6'd51;
	localparam logic [5:0] K_ERROR  = 6'd52;
	localparam logic [5:0] K_NONE   = 6'd63;

	localparam logic [2:0] E_NONE       = 3'd0;
	localparam logic [2:0] E_BAD_CHAR   = 3'd1;
	localparam logic [2:0] E_BAD_ESCAPE = 3'd2;
	localparam logic [2:0] E_UNTERM     = 3'd3;
	localparam logic [2:0] E_EMPTY      = 3'd4;
	localparam logic [2:0] E_MULTI      = 3'd5;
	localparam logic [2:0] E_OVERFLOW   = 3'd6;

	localparam logic [62:0] INT_MAX = {63{1'b1}};

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_source;
	} in_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [23:0] start_offset;
		logic [23:0] lexeme_length;
		logic [23:0] line_number;
		logic [62:0] int_value;
		logic [7:0]  char_value;
		logic        is_integer;
		logic [2:0]  error_code;
		logic        last;
	} out_t;

	// Up to three tokens produced by one accepted byte.
	typedef struct packed {
		logic [1:0]     cnt;
		out_t [2:0]     tok;
	} burst_t;

endpackage

@@ design/stt_if.sv @@
// Valid/ready channel interfaces for source bytes and tokens.
// Depends on stt_pkg.
`timescale 1ns / 1ps

interface stt_in_if;
	logic          valid;
	logic          ready;
	stt_pkg::in_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface stt_out_if;
	logic          valid;
	logic          ready;
	stt_pkg::out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ design/stt_scan.sv @@
// Scanner state and per-byte next-state logic; produces up to three tokens per transfer.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_scan #(
	parameter int MAX_KEYWORD_CHARS = 8,
	parameter int POSITION_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  stt_pkg::in_t    din,
	output stt_pkg::burst_t burst
);

	localparam int P  = POSITION_BITS;
	localparam int MK = MAX_KEYWORD_CHARS;
	localparam int CW = $clog2(MK + 2);

	typedef enum logic [9:0] {
		M_IDLE     = 10'b0000000001,
		M_OP       = 10'b0000000010,
		M_COMMENT  = 10'b0000000100,
		M_IDENT    = 10'b0000001000,
		M_NUM      = 10'b0000010000,
		M_NUMDOT   = 10'b0000100000,
		M_FRAC     = 10'b0001000000,
		M_CH_OPEN  = 10'b0010000000,
		M_CH_ESC   = 10'b0100000000,
		M_CH_CLOSE = 10'b1000000000
	} mode_t;

	mode_t          mode_q, n_mode;
	logic [7:0]     op_q, n_op;
	logic [62:0]    acc_q, n_acc;
	logic           ovf_q, n_ovf;
	logic [7:0]     win_q [MK];
	logic [7:0]     n_win [MK];
	logic [CW-1:0]  wcnt_q, n_wcnt;
	logic [P-1:0]   tstart_q, n_tstart;
	logic [P-1:0]   pos_q, n_pos;
	logic [P-1:0]   line_q, n_line;
	logic [7:0]     lit_q, n_lit;
	logic           halt_q, n_halt;

	stt_pkg::out_t [2:0] toks;
	logic [1:0]     ntok;

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		unique case (c)
			"+": return stt_pkg::K_PLUS;
			"-": return stt_pkg::K_MINUS;
			"*": return stt_pkg::K_STAR;
			"/": return stt_pkg::K_SLASH;
			"&": return stt_pkg::K_AMP;
			"|": return stt_pkg::K_PIPE;
			"!": return stt_pkg::K_BANG;
			"=": return stt_pkg::K_ASSIGN;
			"<": return stt_pkg::K_LT;
			">": return stt_pkg::K_GT;
			default: return stt_pkg::K_NONE;
		endcase
	endfunction

	function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
		if (a == "&") return (b == "&") ? stt_pkg::K_ANDAND : stt_pkg::K_NONE;
		if (a == "|") return (b == "|") ? stt_pkg::K_OROR : stt_pkg::K_NONE;
		if (b != "=") return stt_pkg::K_NONE;
		unique case (a)
			"+": return stt_pkg::K_PLUSEQ;
			"-": return stt_pkg::K_MINUSEQ;
			"*": return stt_pkg::K_STAREQ;
			"/": return stt_pkg::K_SLASHEQ;
			"!": return stt_pkg::K_NE;
			"=": return stt_pkg::K_EQEQ;
			"<": return stt_pkg::K_LE;
			">": return stt_pkg::K_GE;
			default: return stt_pkg::K_NONE;
		endcase
	endfunction

	// w holds the first eight identifier bytes, first byte in the top bits.
	function automatic logic [5:0] kw_kind(input logic [63:0] w, input logic [3:0] n);
		logic [5:0] k;
		k = stt_pkg::K_IDENT;
		unique case (n)
			4'd2: if (w[63:48] == "if") k = stt_pkg::K_IF;
			4'd3: begin
				if (w[63:40] == "let") k = stt_pkg::K_LET;
				else if (w[63:40] == "nil") k = stt_pkg::K_NIL;
				else if (w[63:40] == "for") k = stt_pkg::K_FOR;
				else if (w[63:40] == "int") k = stt_pkg::K_INT;
			end
			4'd4: begin
				if (w[63:32] == "auto") k = stt_pkg::K_LET;
				else if (w[63:32] == "true") k = stt_pkg::K_TRUE;
				else if (w[63:32] == "else") k = stt_pkg::K_ELSE;
				else if (w[63:32] == "long") k = stt_pkg::K_LONG;
				else if (w[63:32] == "bool") k = stt_pkg::K_BOOL;
				else if (w[63:32] == "char") k = stt_pkg::K_CHARKW;
			end
			4'd5: begin
				if (w[63:24] == "print") k = stt_pkg::K_PRINT;
				else if (w[63:24] == "input") k = stt_pkg::K_INPUT;
				else if (w[63:24] == "false") k = stt_pkg::K_FALSE;
				else if (w[63:24] == "while") k = stt_pkg::K_WHILE;
				else if (w[63:24] == "break") k = stt_pkg::K_BREAK;
				else if (w[63:24] == "float") k = stt_pkg::K_FLOAT;
			end
			4'd6: if (w[63:16] == "double") k = stt_pkg::K_DOUBLE;
			4'd7: if (w[63:8] == "integer") k = stt_pkg::K_INT;
			4'd8: if (w == "continue") k = stt_pkg::K_CONTINUE;
			default: k = stt_pkg::K_IDENT;
		endcase
		return k;
	endfunction

	function automatic stt_pkg::out_t mk(input logic [5:0] k, input logic [P-1:0] st,
			input logic [P-1:0] ln, input logic [62:0] iv, input logic [7:0] cv,
			input logic ii, input logic [2:0] ec);
		stt_pkg::out_t t;
		t.kind = k;
		t.start_offset = 24'(st);
		t.lexeme_length = 24'(ln);
		t.line_number = '0;
		t.int_value = iv;
		t.char_value = cv;
		t.is_integer = ii;
		t.error_code = ec;
		t.last = 1'b0;
		return t;
	endfunction

	logic [63:0]  win8;
	logic [3:0]   wcnt8;
	logic [5:0]   idk;
	logic [66:0]  prod;

	always_comb begin
		for (int i = 0; i < 8; i++) win8[63-8*i -: 8] = win_q[i];
		wcnt8 = (wcnt_q <= CW'(8)) ? 4'(wcnt_q) : 4'hF;
		idk = kw_kind(win8, wcnt8);
		prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 67'(din.ch - 8'h30);
	end

	always_comb begin
		logic [7:0]   c;
		logic [P-1:0] incl;
		logic [P-1:0] pm1;
		logic [5:0]   k;
		logic         st;
		logic         dig;
		logic         alpha;
		c = din.ch;
		incl = pos_q + P'(1) - tstart_q;
		pm1 = pos_q - P'(1);
		k = stt_pkg::K_NONE;
		st = 1'b0;
		dig = (c >= "0") && (c <= "9");
		alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
		n_mode = mode_q;
		n_op = op_q;
		n_acc = acc_q;
		n_ovf = ovf_q;
		n_win = win_q;
		n_wcnt = wcnt_q;
		n_tstart = tstart_q;
		n_pos = pos_q;
		n_line = line_q;
		n_lit = lit_q;
		n_halt = halt_q;
		toks = '0;
		ntok = 2'd0;
		if (fire && din.end_of_source) begin
			if (!halt_q) begin
				unique case (mode_q)
					M_OP: begin
						k = single_kind(op_q);
						if (k == stt_pkg::K_NONE) k = 6'd0;
						toks[ntok] = mk(k, tstart_q, P'(1), '0, '0, 1'b0, stt_pkg::E_NONE);
						ntok = ntok + 2'd1;
					end
					M_IDENT: begin
						toks[ntok] = mk(idk, tstart_q, pos_q - tstart_q, '0, '0, 1'b0,
							stt_pkg::E_NONE);
						ntok = ntok + 2'd1;
					end
					M_NUM: begin
						if (ovf_q) toks[ntok] = mk(stt_pkg::K_ERROR, tstart_q, pos_q - tstart_q,
							'0, '0, 1'b0, stt_pkg::E_OVERFLOW);
						else toks[ntok] = mk(stt_pkg::K_NUMBER, tstart_q, pos_q - tstart_q,
							acc_q, '0, 1'b1, stt_pkg::E_NONE);
						ntok = ntok + 2'd1;
					end
					M_NUMDOT: begin
						if (ovf_q) begin
							toks[ntok] = mk(stt_pkg::K_ERROR, tstart_q, pm1 - tstart_q,
								'0, '0, 1'b0, stt_pkg::E_OVERFLOW);
							ntok = ntok + 2'd1;
						end else begin
							toks[ntok] = mk(stt_pkg::K_NUMBER, tstart_q, pm1 - tstart_q,
								acc_q, '0, 1'b1, stt_pkg::E_NONE);
							ntok = ntok + 2'd1;
							toks[ntok] = mk(stt_pkg::K_DOT, pm1, P'(1), '0, '0, 1'b0,
								stt_pkg::E_NONE);
							ntok = ntok + 2'd1;
						end
					end
					M_FRAC: begin
						toks[ntok] = mk(stt_pkg::K_NUMBER, tstart_q, pos_q - tstart_q,
							'0, '0, 1'b0, stt_pkg::E_NONE);
						ntok = ntok + 2'd1;
					end
					M_CH_OPEN, M_CH_ESC, M_CH_CLOSE: begin
						toks[ntok] = mk(stt_pkg::K_ERROR, tstart_q, pos_q - tstart_q,
							'0, '0, 1'b0, stt_pkg::E_UNTERM);
						ntok = ntok + 2'd1;
					end
					default: ;
				endcase
			end
			toks[ntok] = mk(stt_pkg::K_EOF, pos_q, '0, '0, '0, 1'b0, stt_pkg::E_NONE);
			ntok = ntok + 2'd1;
			n_mode = M_IDLE;
			n_op = '0;
			n_acc = '0;
			n_ovf = 1'b0;
			for (int i = 0; i < MK; i++) n_win[i] = '0;
			n_wcnt = '0;
			n_tstart = '0;
			n_pos = '0;
			n_line = P'(1);
			n_lit = '0;
			n_halt = 1'b0;
		end else if (fire && !halt_q) begin
			unique case (mode_q)
				M_OP: begin
					n_mode = M_IDLE;
					k = pair_kind(op_q, c);
					if ((op_q == "/") && (c == "/")) begin
						n_mode = M_COMMENT;
					end else if (k != stt_pkg::K_NONE) begin
						toks[ntok] = mk(k, tstart_q, P'(2), '0, '0, 1'b0, stt_pkg::E_NONE);
						ntok = ntok + 2'd1;
					end else begin
						k = single_kind(op_q);
						if (k == stt_pkg::K_NONE) k = 6'd0;
						toks[ntok] = mk(k, tstart_q, P'(1), '0, '0, 1'b0, stt_pkg::E_NONE);
						ntok = ntok + 2'd1;
						st = 1'b1;
					end
				end
				M_COMMENT: begin
					if (c == 8'h0A) begin
						n_mode = M_IDLE;
						st = 1'b1;
					end
				end
				M_IDENT: begin
					if (alpha || dig) begin
						for (int i = 0; i < MK; i++)
							if (wcnt_q == CW'(i)) n_win[i] = c;
						if (wcnt_q <= CW'(MK)) n_wcnt = wcnt_q + CW'(1);
					end else begin
						toks[ntok] = mk(idk, tstart_q, pos_q - tstart_q, '0, '0, 1'b0,
							stt_pkg::E_NONE);
						ntok = ntok + 2'd1;
						n_mode = M_IDLE;
						st = 1'b1;
					end
				end
				M_NUM: begin
					if (dig) begin
						if (prod > 67'(stt_pkg::INT_MAX)) n_ovf = 1'b1;
						else n_acc = prod[62:0];
					end else if (c == ".") begin
						n_mode = M_NUMDOT;
					end else begin
						n_mode = M_IDLE;
						if (ovf_q) begin
							toks[ntok] = mk(stt_pkg::K_ERROR, tstart_q, pos_q - tstart_q,
								'0, '0, 1'b0, stt_pkg::E_OVERFLOW);
							n_halt = 1'b1;
						end else begin
							toks[ntok] = mk(stt_pkg::K_NUMBER, tstart_q, pos_q - tstart_q,
								acc_q, '0, 1'b1, stt_pkg::E_NONE);
							st = 1'b1;
						end
						ntok = ntok + 2'd1;
					end
				end
				M_NUMDOT: begin
					if (dig) begin
						n_mode = M_FRAC;
					end else begin
						n_mode = M_IDLE;
						if (ovf_q) begin
							toks[ntok] = mk(stt_pkg::K_ERROR, tstart_q, pm1 - tstart_q,
								'0, '0, 1'b0, stt_pkg::E_OVERFLOW);
							ntok = ntok + 2'd1;
							n_halt = 1'b1;
						end else begin
							toks[ntok] = mk(stt_pkg::K_NUMBER, tstart_q, pm1 - tstart_q,
								acc_q, '0, 1'b1, stt_pkg::E_NONE);
							ntok = ntok + 2'd1;
							toks[ntok] = mk(stt_pkg::K_DOT, pm1, P'(1), '0, '0, 1'b0,
								stt_pkg::E_NONE);
							ntok = ntok + 2'd1;
							st = 1'b1;
						end
					end
				end
				M_FRAC: begin
					if (!dig) begin
						toks[ntok] = mk(stt_pkg::K_NUMBER, tstart_q, pos_q - tstart_q,
							'0, '0, 1'b0, stt_pkg::E_NONE);
						ntok = ntok + 2'd1;
						n_mode = M_IDLE;
						st = 1'b1;
					end
				end
				M_CH_OPEN: begin
					if (c == 8'h0A || c == "'") begin
						toks[ntok] = mk(stt_pkg::K_ERROR, tstart_q, incl, '0, '0, 1'b0,
							(c == 8'h0A) ? stt_pkg::E_UNTERM : stt_pkg::E_EMPTY);
						ntok = ntok + 2'd1;
						n_halt = 1'b1;
						n_mode = M_IDLE;
					end else if (c == 8'h5C) begin
						n_mode = M_CH_ESC;
					end else begin
						n_lit = c;
						n_mode = M_CH_CLOSE;
					end
				end
				M_CH_ESC: begin
					n_mode = M_CH_CLOSE;
					unique case (c)
						"n": n_lit = 8'd10;
						"t": n_lit = 8'd9;
						"r": n_lit = 8'd13;
						"0": n_lit = 8'd0;
						8'h5C: n_lit = 8'h5C;
						"'": n_lit = 8'h27;
						default: begin
							toks[ntok] = mk(stt_pkg::K_ERROR, tstart_q, incl, '0, '0, 1'b0,
								(c == 8'h0A) ? stt_pkg::E_UNTERM : stt_pkg::E_BAD_ESCAPE);
							ntok = ntok + 2'd1;
							n_halt = 1'b1;
							n_mode = M_IDLE;
						end
					endcase
				end
				M_CH_CLOSE: begin
					n_mode = M_IDLE;
					if (c == "'") begin
						toks[ntok] = mk(stt_pkg::K_CHAR, tstart_q, incl, '0, lit_q, 1'b0,
							stt_pkg::E_NONE);
					end else begin
						toks[ntok] = mk(stt_pkg::K_ERROR, tstart_q, incl, '0, '0, 1'b0,
							(c == 8'h0A) ? stt_pkg::E_UNTERM : stt_pkg::E_MULTI);
						n_halt = 1'b1;
					end
					ntok = ntok + 2'd1;
				end
				default: begin
					n_mode = M_IDLE;
					st = 1'b1;
				end
			endcase
			if (st) begin
				n_tstart = pos_q;
				k = stt_pkg::K_NONE;
				unique case (c)
					"(": k = stt_pkg::K_LPAREN;
					")": k = stt_pkg::K_RPAREN;
					"{": k = stt_pkg::K_LBRACE;
					"}": k = stt_pkg::K_RBRACE;
					",": k = stt_pkg::K_COMMA;
					".": k = stt_pkg::K_DOT;
					";": k = stt_pkg::K_SEMI;
					"%": k = stt_pkg::K_PERCENT;
					"^": k = stt_pkg::K_CARET;
					"~": k = stt_pkg::K_TILDE;
					default: k = stt_pkg::K_NONE;
				endcase
				if (k != stt_pkg::K_NONE) begin
					toks[ntok] = mk(k, pos_q, P'(1), '0, '0, 1'b0, stt_pkg::E_NONE);
					ntok = ntok + 2'd1;
				end else if (c == "'") begin
					n_mode = M_CH_OPEN;
					n_lit = '0;
				end else if (c == " " || c == 8'h0D || c == 8'h09) begin
					n_mode = n_mode;
				end else if (c == 8'h0A) begin
					n_line = line_q + P'(1);
				end else if (single_kind(c) != stt_pkg::K_NONE) begin
					n_op = c;
					n_mode = M_OP;
				end else if (dig) begin
					n_acc = 63'(c - 8'h30);
					n_ovf = 1'b0;
					n_mode = M_NUM;
				end else if (alpha) begin
					n_win[0] = c;
					n_wcnt = CW'(1);
					n_mode = M_IDENT;
				end else begin
					toks[ntok] = mk(stt_pkg::K_ERROR, pos_q, P'(1), '0, '0, 1'b0,
						stt_pkg::E_BAD_CHAR);
					ntok = ntok + 2'd1;
					n_halt = 1'b1;
					n_mode = M_IDLE;
				end
			end
			n_pos = pos_q + P'(1);
		end
		for (int i = 0; i < 3; i++) toks[i].line_number = 24'(line_q);
		if (ntok != 2'd0) toks[ntok - 2'd1].last = 1'b1;
		burst.cnt = ntok;
		burst.tok = toks;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			op_q <= '0;
			acc_q <= '0;
			ovf_q <= 1'b0;
			for (int i = 0; i < MK; i++) win_q[i] <= '0;
			wcnt_q <= '0;
			tstart_q <= '0;
			pos_q <= '0;
			line_q <= P'(1);
			lit_q <= '0;
			halt_q <= 1'b0;
		end else begin
			mode_q <= n_mode;
			op_q <= n_op;
			acc_q <= n_acc;
			ovf_q <= n_ovf;
			win_q <= n_win;
			wcnt_q <= n_wcnt;
			tstart_q <= n_tstart;
			pos_q <= n_pos;
			line_q <= n_line;
			lit_q <= n_lit;
			halt_q <= n_halt;
		end
	end

endmodule

@@ design/stt_queue.sv @@
// Four-entry token queue: takes a burst of up to three tokens, drains one per transfer.
// Depends on stt_pkg and stt_out_if.
`timescale 1ns / 1ps

module stt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  stt_pkg::burst_t burst,
	output logic            space,
	stt_out_if.source       tok_out
);

	stt_pkg::out_t mem [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;
	logic       pop;

	assign pop = tok_out.valid && tok_out.ready;
	assign space = (count_q <= 3'd1);
	assign tok_out.valid = (count_q != 3'd0);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			if (2'(i) < burst.cnt) mem[wr_q + 2'(i)] <= burst.tok[i];
		tok_out.data <= mem[pop ? rd_q + 2'd1 : rd_q];
		if (count_q == 3'd0 || (pop && count_q == 3'd1)) tok_out.data <= burst.tok[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + burst.cnt;
			rd_q <= rd_q + 2'(pop);
			count_q <= count_q + 3'(burst.cnt) - 3'(pop);
		end
	end

`ifndef SYNTH
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n) count_q <= 3'd4)
		else $error("token queue over capacity");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		burst.cnt != 2'd0 |-> count_q <= 3'd1)
		else $error("burst pushed without room");
	a_pop_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && burst.cnt == 2'd0) |=> count_q == $past(count_q) - 3'd1)
		else $error("queue count wrong after transfer");
`endif

endmodule

@@ design/source_text_tokenizer.sv @@
// Source text tokenizer: one byte per transfer in, tokens out.
// Tokens ended by a byte (or end marker) pass through the queue to its registered output.
// Throughput: one byte per cycle; a byte yields up to three tokens, drained one per cycle while
// token_out is ready, from a four-entry queue; bytes are taken only while three slots are free.
// Reset: arst_n asynchronously clears scanner state and the queue; no clearing pass.
`timescale 1ns / 1ps

module source_text_tokenizer #(
	parameter int MAX_KEYWORD_CHARS = 8,
	parameter int POSITION_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	stt_in_if.sink    text_in,
	stt_out_if.source token_out
);

	stt_pkg::burst_t burst;
	logic            space;

	assign text_in.ready = space;

	stt_scan #(
		.MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS),
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.fire(text_in.valid && space),
		.din(text_in.data),
		.burst(burst)
	);

	stt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.burst(burst),
		.space(space),
		.tok_out(token_out)
	);

endmodule
